// ===== rtl/core/kaf_pkg.sv =====
// kaf_pkg: shared types and constants of the angle/bias kalman filter
`default_nettype none
package kaf_pkg;

	// fraction bits of covariance, noise, gain and time step
	localparam int unsigned FRAC = 28;

	// register indexes on the configuration port
	localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
	localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
	localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

	// register reset values
	localparam logic [30:0] ANGLE_NOISE_RST = 31'd268435;
	localparam logic [30:0] BIAS_NOISE_RST  = 31'd805306;
	localparam logic [30:0] MEAS_NOISE_RST  = 31'd8053064;

	// request to the divider
	typedef struct packed {
		logic               start;
		logic signed [31:0] num;
		logic        [31:0] den;
	} kaf_div_req_t;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} kaf_div_stat_t;

	// saturate to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		logic signed [47:0] hi;
		logic signed [47:0] lo;
		hi = 48'sh0000_7fff_ffff;
		lo = -48'sh0000_8000_0000;
		if (v > hi)
			return 32'sh7fff_ffff;
		else if (v < lo)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kaf_if.sv =====
// kaf_if: sample and result channels of the kalman filter
`default_nettype none
interface kaf_sample_if;
	logic               valid;
	logic               ready;
	logic               axis;
	logic signed [24:0] measured_angle;
	logic signed [27:0] gyro_rate;
	logic        [27:0] time_step;

	modport source (output valid, axis, measured_angle, gyro_rate, time_step, input ready);
	modport sink (input valid, axis, measured_angle, gyro_rate, time_step, output ready);
endinterface

interface kaf_result_if;
	logic               valid;
	logic               ready;
	logic               axis_out;
	logic signed [31:0] filtered_angle;
	logic signed [31:0] estimated_bias;

	modport source (output valid, axis_out, filtered_angle, estimated_bias, input ready);
	modport sink (input valid, axis_out, filtered_angle, estimated_bias, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/kaf_mul.sv =====
// kaf_mul: shared signed multiplier with round-to-nearest rescale
`default_nettype none
module kaf_mul (
	input  wire logic               clk,
	input  wire logic signed [33:0] a,
	input  wire logic signed [33:0] b,
	output logic signed [39:0]      r
);
	import kaf_pkg::*;

	logic signed [67:0] prod_q;
	logic signed [67:0] rnd;

	// product register
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	// round half up and drop the fraction bits
	assign rnd = prod_q + (68'sd1 <<< (FRAC - 1));
	assign r   = 40'(rnd >>> FRAC);

endmodule
`default_nettype wire

// ===== rtl/core/kaf_div.sv =====
// kaf_div: restoring divider forming a saturated kalman gain
`default_nettype none
module kaf_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  kaf_pkg::kaf_div_req_t   req,
	output kaf_pkg::kaf_div_stat_t  stat,
	output logic signed [30:0]      gain
);
	import kaf_pkg::*;

	logic        [60:0] rem_q;
	logic        [61:0] dsh_q;
	logic        [30:0] quo_q;
	logic        [4:0]  cnt_q;
	logic               neg_q;
	logic               sat_q;
	logic               busy_q;
	logic               done_q;
	logic        [31:0] mag;
	logic        [60:0] dividend;
	logic               fits;

	// magnitude of the numerator and rounded dividend
	always_comb begin
		mag      = req.num[31] ? 32'(-req.num) : 32'(req.num);
		dividend = {1'b0, mag, 28'd0} + 61'(req.den >> 1);
	end

	assign fits = {1'b0, rem_q} >= dsh_q;

	// one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd30;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= dividend;
			dsh_q <= {req.den, 30'd0};
			quo_q <= '0;
			neg_q <= req.num[31];
			sat_q <= {2'b00, dividend} >= {req.den, 31'd0};
		end else if (busy_q) begin
			if (fits)
				rem_q <= rem_q - dsh_q[60:0];
			quo_q <= {quo_q[29:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	// clamp to the gain range
	always_comb begin
		if (neg_q)
			gain = (sat_q || quo_q > 31'h4000_0000) ? -31'sh4000_0000 : -$signed(quo_q);
		else
			gain = (sat_q || quo_q > 31'h3fff_ffff) ? 31'sh3fff_ffff : $signed(quo_q);
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

// ===== rtl/core/imu_angle_kalman_filter.sv =====
// imu_angle_kalman_filter: top level with sequencer, per-axis state and registers
//
//  channel   dir  handshake        payload
//  sample    in   valid/ready      axis, measured_angle, gyro_rate, time_step
//  result    out  valid/ready      axis_out, filtered_angle, estimated_bias
//  apb       in   psel/penable     paddr[3:0], pwdata, prdata, pready
//
// from accept to the next accept a request runs 4 multiplies for the prediction,
// two gain divisions on the shared divider and 6 multiplies for the update
// when the innovation variance is not positive the divisions and the update are
// skipped
// sample.ready is high only while the sequencer is idle
// a full result register holds the sequencer at write-back until it is taken
// reset clears all axis state and the result valid flag and reloads the noise defaults
`default_nettype none
module imu_angle_kalman_filter #(
	parameter int AXES = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	kaf_sample_if.sink       sample,
	kaf_result_if.source     result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import kaf_pkg::*;

	localparam int IW = (AXES > 1) ? $clog2(AXES) : 1;

	typedef enum logic [4:0] {
		S_IDLE, S_P1, S_P2, S_P3, S_P4, S_P5, S_D0, S_D1, S_D2,
		S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_WB
	} state_t;

	state_t             st_q;
	logic        [30:0] apn_q, bpn_q, mn_q;
	logic signed [31:0] ang_st_q  [AXES];
	logic signed [31:0] bias_st_q [AXES];
	logic signed [31:0] cov_q     [AXES][4];
	logic        [IW-1:0] idx_q;
	logic        [IW-1:0] idx_in;
	logic               axis_q;
	logic signed [24:0] z_q;
	logic signed [27:0] w_q;
	logic        [27:0] dt_q;
	logic signed [31:0] ang_q, bias_q, p0_q, p1_q, p2_q, p3_q, tmp_q;
	logic signed [39:0] t_q;
	logic        [31:0] s_q;
	logic signed [30:0] k0_q, k1_q;
	logic               ov_q;
	logic               ax_out_q;
	logic signed [31:0] fa_q, eb_q;
	logic signed [33:0] ma, mb;
	logic signed [39:0] mr;
	logic signed [33:0] dte, y, inner;
	logic signed [32:0] s_sum;
	logic               wr_en;
	logic               wb_go;
	kaf_div_req_t       dreq;
	kaf_div_stat_t      dstat;
	logic signed [30:0] dgain;

	// configuration registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apn_q <= ANGLE_NOISE_RST;
			bpn_q <= BIAS_NOISE_RST;
			mn_q  <= MEAS_NOISE_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_ANGLE_NOISE: apn_q <= pwdata[30:0];
				REG_BIAS_NOISE:  bpn_q <= pwdata[30:0];
				REG_MEAS_NOISE:  mn_q  <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ANGLE_NOISE: prdata = {1'b0, apn_q};
			REG_BIAS_NOISE:  prdata = {1'b0, bpn_q};
			REG_MEAS_NOISE:  prdata = {1'b0, mn_q};
			default:         prdata = '0;
		endcase
	end

	// shared arithmetic units
	kaf_mul u_mul (.clk(clk), .a(ma), .b(mb), .r(mr));
	kaf_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .stat(dstat), .gain(dgain));

	// operand terms
	assign idx_in = (AXES > 1) ? IW'(sample.axis) : '0;
	assign dte    = {6'd0, dt_q};
	assign y      = 34'(z_q) - 34'(ang_q);
	assign inner  = 34'(t_q) - 34'(p1_q) - 34'(p2_q) + 34'(apn_q);
	assign s_sum  = 33'(p0_q) + 33'(mn_q);

	// write-back fires when the result register is free or being emptied
	assign wb_go  = (st_q == S_WB) && (!ov_q || result.ready);

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (st_q)
			S_P1: begin ma = dte; mb = 34'(w_q) - 34'(bias_q); end
			S_P2: begin ma = dte; mb = 34'(p3_q); end
			S_P3: begin ma = 34'(bpn_q); mb = dte; end
			S_P4: begin ma = dte; mb = inner; end
			S_C1: begin ma = 34'(k0_q); mb = y; end
			S_C2: begin ma = 34'(k1_q); mb = y; end
			S_C3: begin ma = 34'(k0_q); mb = 34'(p0_q); end
			S_C4: begin ma = 34'(k1_q); mb = 34'(p0_q); end
			S_C5: begin ma = 34'(k0_q); mb = 34'(p1_q); end
			S_C6: begin ma = 34'(k1_q); mb = 34'(p1_q); end
			default: ;
		endcase
	end

	// divider requests: P00 first, then P10
	always_comb begin
		dreq.start = ((st_q == S_D0) && (s_sum > 33'sd0)) || ((st_q == S_D1) && dstat.done);
		dreq.num   = (st_q == S_D0) ? p0_q : p2_q;
		dreq.den   = (st_q == S_D0) ? s_sum[31:0] : s_q;
	end

	// sequencer, working registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ov_q <= 1'b0;
			for (int i = 0; i < AXES; i++) begin
				ang_st_q[i]  <= '0;
				bias_st_q[i] <= '0;
				for (int j = 0; j < 4; j++)
					cov_q[i][j] <= '0;
			end
		end else begin
			if (wb_go)
				ov_q <= 1'b1;
			else if (result.valid && result.ready)
				ov_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (sample.valid) begin
						axis_q <= sample.axis;
						idx_q  <= idx_in;
						z_q    <= sample.measured_angle;
						w_q    <= sample.gyro_rate;
						dt_q   <= sample.time_step;
						ang_q  <= ang_st_q[idx_in];
						bias_q <= bias_st_q[idx_in];
						p0_q   <= cov_q[idx_in][0];
						p1_q   <= cov_q[idx_in][1];
						p2_q   <= cov_q[idx_in][2];
						p3_q   <= cov_q[idx_in][3];
						st_q   <= S_P1;
					end
				end
				S_P1: st_q <= S_P2;
				S_P2: begin
					ang_q <= sat32(48'(ang_q) + 48'(mr));
					st_q  <= S_P3;
				end
				S_P3: begin
					t_q  <= mr;
					st_q <= S_P4;
				end
				S_P4: begin
					p3_q <= sat32(48'(p3_q) + 48'(mr));
					p1_q <= sat32(48'(p1_q) - 48'(t_q));
					p2_q <= sat32(48'(p2_q) - 48'(t_q));
					st_q <= S_P5;
				end
				S_P5: begin
					p0_q <= sat32(48'(p0_q) + 48'(mr));
					st_q <= S_D0;
				end
				S_D0: begin
					s_q  <= s_sum[31:0];
					st_q <= (s_sum > 33'sd0) ? S_D1 : S_WB;
				end
				S_D1: begin
					if (dstat.done) begin
						k0_q <= dgain;
						st_q <= S_D2;
					end
				end
				S_D2: begin
					if (dstat.done) begin
						k1_q <= dgain;
						st_q <= S_C1;
					end
				end
				S_C1: st_q <= S_C2;
				S_C2: begin
					ang_q <= sat32(48'(ang_q) + 48'(mr));
					st_q  <= S_C3;
				end
				S_C3: begin
					bias_q <= sat32(48'(bias_q) + 48'(mr));
					st_q   <= S_C4;
				end
				S_C4: begin
					tmp_q <= sat32(48'(p0_q) - 48'(mr));
					st_q  <= S_C5;
				end
				S_C5: begin
					p2_q <= sat32(48'(p2_q) - 48'(mr));
					p0_q <= tmp_q;
					st_q <= S_C6;
				end
				S_C6: begin
					tmp_q <= sat32(48'(p1_q) - 48'(mr));
					st_q  <= S_C7;
				end
				S_C7: begin
					p3_q <= sat32(48'(p3_q) - 48'(mr));
					p1_q <= tmp_q;
					st_q <= S_WB;
				end
				S_WB: begin
					if (wb_go) begin
						ang_st_q[idx_q]  <= ang_q;
						bias_st_q[idx_q] <= bias_q;
						cov_q[idx_q][0]  <= p0_q;
						cov_q[idx_q][1]  <= p1_q;
						cov_q[idx_q][2]  <= p2_q;
						cov_q[idx_q][3]  <= p3_q;
						st_q             <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (wb_go) begin
			ax_out_q <= axis_q;
			fa_q     <= ang_q;
			eb_q     <= bias_q;
		end
	end

	assign sample.ready          = (st_q == S_IDLE);
	assign result.valid          = ov_q;
	assign result.axis_out       = ax_out_q;
	assign result.filtered_angle = fa_q;
	assign result.estimated_bias = eb_q;

`ifndef SYNTHESIS
	a_div_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.done |-> $past(dstat.busy))
		else $error("divider done without a running division");

	a_div_only_in_gain: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.busy |-> (st_q == S_D1 || st_q == S_D2))
		else $error("divider busy outside the gain steps");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> !sample.ready)
		else $error("sample taken while a request is in work");
`endif

endmodule
`default_nettype wire
